>>> src/kclc_pkg.sv
// shared types and constants for the keypad code lock controller
package kclc_pkg;

  localparam int CODE_DIGITS_DEF = 6;

  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_ENTRY  = 2'd1;
  localparam logic [1:0] MODE_OPEN   = 2'd2;
  localparam logic [1:0] MODE_REVISE = 2'd3;

  localparam logic [3:0] KEY_DIGIT_LO = 4'd0;
  localparam logic [3:0] KEY_DIGIT_HI = 4'd9;
  localparam logic [3:0] KEY_BACK     = 4'd10;
  localparam logic [3:0] KEY_START    = 4'd11;
  localparam logic [3:0] KEY_REVISE   = 4'd12;

  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam int         CFG_IDX_W      = 1;
  localparam int         CFG_DATA_W     = 8;
  localparam logic [0:0] CFG_OPEN_HOLD  = 1'd0;
  localparam logic [0:0] CFG_ERROR_HOLD = 1'd1;

  localparam logic [7:0] HOLD_RESET   = 8'd100;
  localparam logic [3:0] STORED_RESET = 4'd8;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] err_timer;
    logic [7:0] open_timer;
    logic       err_run;
    logic       open_run;
    logic       relay;
    logic       err_lamp;
    logic       entry_lamp;
    logic       revise_lamp;
  } ctl_t;

endpackage

>>> src/kclc_cfg.sv
// hold time configuration registers
module kclc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [kclc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kclc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [7:0]                     open_hold,
  output logic [7:0]                     error_hold
);
  import kclc_pkg::*;

  logic [7:0] open_hold_r;
  logic [7:0] error_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_hold_r  <= HOLD_RESET;
      error_hold_r <= HOLD_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OPEN_HOLD:  open_hold_r  <= cfg_wdata[7:0];
        CFG_ERROR_HOLD: error_hold_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign open_hold  = open_hold_r;
  assign error_hold = error_hold_r;

endmodule

>>> src/kclc_step.sv
// next-state logic for one key event or timer tick
module kclc_step #(
  parameter  int CODE_DIGITS = kclc_pkg::CODE_DIGITS_DEF,
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1),
  localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1
) (
  input  logic                 func,
  input  logic [3:0]           key_code,
  input  logic [7:0]           open_hold,
  input  logic [7:0]           error_hold,
  input  kclc_pkg::ctl_t       ctl,
  input  logic [CNT_W-1:0]     count,
  input  logic [3:0]           stored [CODE_DIGITS],
  input  logic [3:0]           entered [CODE_DIGITS],
  output kclc_pkg::ctl_t       ctl_nxt,
  output logic [CNT_W-1:0]     count_nxt,
  output logic [3:0]           stored_nxt [CODE_DIGITS],
  output logic [3:0]           entered_nxt [CODE_DIGITS],
  output logic                 wr,
  output logic [IDX_W-1:0]     wr_idx
);
  import kclc_pkg::*;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(CODE_DIGITS);

  logic [7:0]       e_inc;
  logic [7:0]       o_inc;
  logic [CNT_W-1:0] pos;
  logic             match;

  assign e_inc = ctl.err_timer + 8'd1;
  assign o_inc = ctl.open_timer + 8'd1;

  always_comb begin
    ctl_nxt     = ctl;
    count_nxt   = count;
    stored_nxt  = stored;
    entered_nxt = entered;
    wr          = 1'b0;
    wr_idx      = '0;
    pos         = '0;
    match       = 1'b1;
    if (func == FUNC_TICK) begin
      // error timer is serviced before the open timer
      if (ctl.err_run) begin
        if (e_inc >= error_hold) begin
          ctl_nxt.err_run    = 1'b0;
          ctl_nxt.err_timer  = '0;
          ctl_nxt.err_lamp   = 1'b0;
          ctl_nxt.entry_lamp = 1'b0;
          ctl_nxt.mode       = MODE_CLOSED;
        end else begin
          ctl_nxt.err_timer = e_inc;
        end
      end
      if (ctl.open_run) begin
        if (o_inc >= open_hold) begin
          ctl_nxt.open_run   = 1'b0;
          ctl_nxt.open_timer = '0;
          ctl_nxt.relay      = 1'b0;
          ctl_nxt.mode       = MODE_CLOSED;
        end else begin
          ctl_nxt.open_timer = o_inc;
        end
      end
    end else begin
      case (ctl.mode)
        MODE_CLOSED: begin
          if (key_code == KEY_START) begin
            ctl_nxt.mode       = MODE_ENTRY;
            ctl_nxt.entry_lamp = 1'b1;
            count_nxt          = '0;
          end
        end
        MODE_ENTRY: begin
          if (key_code inside {[KEY_DIGIT_LO:KEY_DIGIT_HI]}) begin
            if (count < FULL) begin
              entered_nxt[count[IDX_W-1:0]] = key_code;
              count_nxt = count + CNT_W'(1);
              if (count_nxt == FULL) begin
                for (int i = 0; i < CODE_DIGITS; i++) begin
                  if (entered_nxt[i] != stored[i]) match = 1'b0;
                end
                if (match) begin
                  ctl_nxt.relay      = 1'b1;
                  ctl_nxt.entry_lamp = 1'b0;
                  ctl_nxt.open_timer = '0;
                  ctl_nxt.open_run   = 1'b1;
                  ctl_nxt.mode       = MODE_OPEN;
                end else begin
                  ctl_nxt.err_run  = 1'b1;
                  ctl_nxt.err_lamp = 1'b1;
                end
              end
            end
          end else if (key_code == KEY_BACK) begin
            ctl_nxt.err_lamp  = 1'b0;
            ctl_nxt.err_run   = 1'b0;
            ctl_nxt.err_timer = '0;
            if (count != '0) count_nxt = count - CNT_W'(1);
          end
        end
        MODE_OPEN: begin
          if (key_code == KEY_REVISE) begin
            ctl_nxt.open_run    = 1'b0;
            ctl_nxt.relay       = 1'b0;
            ctl_nxt.revise_lamp = 1'b1;
            ctl_nxt.mode        = MODE_REVISE;
            count_nxt           = '0;
          end
        end
        default: begin
          if (key_code inside {[KEY_DIGIT_LO:KEY_DIGIT_HI]}) begin
            // past the last position the last digit is overwritten again
            if (count < FULL) count_nxt = count + CNT_W'(1);
            pos    = count_nxt - CNT_W'(1);
            wr_idx = pos[IDX_W-1:0];
            wr     = 1'b1;
            for (int i = 0; i < CODE_DIGITS; i++) begin
              if (wr_idx == IDX_W'(i)) stored_nxt[i] = key_code;
            end
          end else if (key_code == KEY_BACK) begin
            if (count != '0) count_nxt = count - CNT_W'(1);
          end else if (key_code == KEY_REVISE) begin
            if (count == FULL) begin
              ctl_nxt.mode        = MODE_CLOSED;
              ctl_nxt.revise_lamp = 1'b0;
            end
          end
        end
      endcase
    end
  end

endmodule

>>> src/keypad_code_lock_controller.sv
// keypad code lock: input stage, lock state, result register
// path: an accepted beat goes through the input register and then the result register
// throughput: one beat per cycle while the result channel is not stalled; the lock
// state is updated as a beat moves from the input register to the result register
// reset (synchronous, rst_n low): lock closed, lamps and relay off, timers stopped,
// stored code all eights, both hold times 100 ticks
module keypad_code_lock_controller #(
  parameter  int CODE_DIGITS = kclc_pkg::CODE_DIGITS_DEF,
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1),
  localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [kclc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kclc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [3:0]                     in_key_code,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_lock_mode,
  output logic [CNT_W-1:0]               out_digit_count,
  output logic                           out_relay_on,
  output logic                           out_error_lamp,
  output logic                           out_entry_lamp,
  output logic                           out_revise_lamp,
  output logic                           out_store_write,
  output logic [IDX_W-1:0]               out_store_index,
  output logic [3:0]                     out_store_digit
);
  import kclc_pkg::*;

  logic [7:0]       open_hold;
  logic [7:0]       error_hold;

  logic             in_valid_r;
  logic             in_func_r;
  logic [3:0]       in_key_r;
  logic             advance;
  logic             in_take;

  ctl_t             ctl_r;
  ctl_t             ctl_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [3:0]       stored_r [CODE_DIGITS];
  logic [3:0]       stored_nxt [CODE_DIGITS];
  logic [3:0]       entered_r [CODE_DIGITS];
  logic [3:0]       entered_nxt [CODE_DIGITS];
  logic             wr;
  logic [IDX_W-1:0] wr_idx;

  logic             out_valid_r;
  logic [1:0]       out_mode_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_relay_r;
  logic             out_err_r;
  logic             out_entry_r;
  logic             out_revise_r;
  logic             out_wr_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [3:0]       out_digit_r;

  kclc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .open_hold  (open_hold),
    .error_hold (error_hold)
  );

  kclc_step #(.CODE_DIGITS(CODE_DIGITS)) u_step (
    .func        (in_func_r),
    .key_code    (in_key_r),
    .open_hold   (open_hold),
    .error_hold  (error_hold),
    .ctl         (ctl_r),
    .count       (count_r),
    .stored      (stored_r),
    .entered     (entered_r),
    .ctl_nxt     (ctl_nxt),
    .count_nxt   (count_nxt),
    .stored_nxt  (stored_nxt),
    .entered_nxt (entered_nxt),
    .wr          (wr),
    .wr_idx      (wr_idx)
  );

  // the held beat moves on when the result register is empty or draining
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_func_r <= in_func;
      in_key_r  <= in_key_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= '0;
      count_r <= '0;
      for (int i = 0; i < CODE_DIGITS; i++) stored_r[i] <= STORED_RESET;
    end else if (advance) begin
      ctl_r    <= ctl_nxt;
      count_r  <= count_nxt;
      stored_r <= stored_nxt;
    end
  end

  // entered digits are only compared after being written in the current entry
  always_ff @(posedge clk) begin
    if (advance) entered_r <= entered_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode_r   <= ctl_nxt.mode;
      out_count_r  <= count_nxt;
      out_relay_r  <= ctl_nxt.relay;
      out_err_r    <= ctl_nxt.err_lamp;
      out_entry_r  <= ctl_nxt.entry_lamp;
      out_revise_r <= ctl_nxt.revise_lamp;
      out_wr_r     <= wr;
      out_idx_r    <= wr ? wr_idx : '0;
      out_digit_r  <= wr ? in_key_r : 4'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lock_mode   = out_mode_r;
  assign out_digit_count = out_count_r;
  assign out_relay_on    = out_relay_r;
  assign out_error_lamp  = out_err_r;
  assign out_entry_lamp  = out_entry_r;
  assign out_revise_lamp = out_revise_r;
  assign out_store_write = out_wr_r;
  assign out_store_index = out_idx_r;
  assign out_store_digit = out_digit_r;

  a_relay_open : assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.relay == (ctl_r.mode == MODE_OPEN))
    else $error("relay state disagrees with open mode");

  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CODE_DIGITS))
    else $error("digit count beyond code length");

  a_write_revise : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_wr_r |-> out_mode_r == MODE_REVISE)
    else $error("stored digit write outside revise mode");

  a_advance_out : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced beat missing from result register");

endmodule

>>> test/tb_keypad_code_lock_controller.sv
// self-checking testbench for the keypad code lock controller
`timescale 1ns / 1ps

module tb_keypad_code_lock_controller;
  import kclc_pkg::*;

  localparam int         N_DIGITS   = CODE_DIGITS_DEF;
  localparam logic [3:0] KEY_SPARE  = 4'd13;
  localparam int         IDLE_LIMIT = 3000;
  localparam int         HOLD_OFF   = 80;

  typedef struct packed {
    logic       func;
    logic [3:0] key;
  } key_beat_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] count;
    logic       relay;
    logic       err;
    logic       entry;
    logic       revise;
    logic       wr;
    logic [2:0] idx;
    logic [3:0] dig;
  } lock_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = FUNC_KEY;
  logic [3:0] in_key_code = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_lock_mode;
  logic [2:0] out_digit_count;
  logic out_relay_on;
  logic out_error_lamp;
  logic out_entry_lamp;
  logic out_revise_lamp;
  logic out_store_write;
  logic [2:0] out_store_index;
  logic [3:0] out_store_digit;

  keypad_code_lock_controller dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_key_code     (in_key_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_lock_mode   (out_lock_mode),
    .out_digit_count (out_digit_count),
    .out_relay_on    (out_relay_on),
    .out_error_lamp  (out_error_lamp),
    .out_entry_lamp  (out_entry_lamp),
    .out_revise_lamp (out_revise_lamp),
    .out_store_write (out_store_write),
    .out_store_index (out_store_index),
    .out_store_digit (out_store_digit)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  key_beat_t  beat_q[$];
  lock_view_t view_q[$];
  int unsigned n_pushed = 0;
  int unsigned n_taken = 0;
  int n_errors = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  // lock state as the block should hold it
  logic [3:0] code_store [N_DIGITS];
  logic [3:0] code_typed [N_DIGITS];
  logic [1:0] lk_mode;
  logic [2:0] lk_count;
  logic [7:0] err_tmr, open_tmr;
  logic [7:0] open_hold, err_hold;
  bit err_run, open_run;
  bit relay, err_lamp, entry_lamp, revise_lamp;

  task automatic reset_lock();
    for (int i = 0; i < N_DIGITS; i++) begin
      code_store[i] = STORED_RESET;
      code_typed[i] = '0;
    end
    lk_mode = MODE_CLOSED;
    lk_count = '0;
    err_tmr = '0;
    open_tmr = '0;
    open_hold = HOLD_RESET;
    err_hold = HOLD_RESET;
    err_run = 1'b0;
    open_run = 1'b0;
    relay = 1'b0;
    err_lamp = 1'b0;
    entry_lamp = 1'b0;
    revise_lamp = 1'b0;
  endtask

  task automatic advance_lock(input logic fn, input logic [3:0] key);
    lock_view_t v;
    logic wr;
    logic [2:0] widx;
    logic [3:0] wdig;
    bit same;
    wr = 1'b0;
    widx = '0;
    wdig = '0;
    if (fn == FUNC_TICK) begin
      // error timer is served before the open timer
      if (err_run) begin
        err_tmr = err_tmr + 8'd1;
        if (err_tmr >= err_hold) begin
          err_run = 1'b0;
          err_tmr = '0;
          err_lamp = 1'b0;
          entry_lamp = 1'b0;
          lk_mode = MODE_CLOSED;
        end
      end
      if (open_run) begin
        open_tmr = open_tmr + 8'd1;
        if (open_tmr >= open_hold) begin
          open_run = 1'b0;
          open_tmr = '0;
          relay = 1'b0;
          lk_mode = MODE_CLOSED;
        end
      end
    end else begin
      case (lk_mode)
        MODE_CLOSED: begin
          if (key == KEY_START) begin
            lk_mode = MODE_ENTRY;
            lk_count = '0;
            entry_lamp = 1'b1;
          end
        end
        MODE_ENTRY: begin
          if (key <= KEY_DIGIT_HI) begin
            if (lk_count < N_DIGITS) begin
              code_typed[lk_count] = key;
              lk_count = lk_count + 3'd1;
              if (lk_count == N_DIGITS) begin
                same = 1'b1;
                for (int i = 0; i < N_DIGITS; i++)
                  if (code_typed[i] != code_store[i]) same = 1'b0;
                if (same) begin
                  relay = 1'b1;
                  entry_lamp = 1'b0;
                  open_tmr = '0;
                  open_run = 1'b1;
                  lk_mode = MODE_OPEN;
                end else begin
                  err_run = 1'b1;
                  err_lamp = 1'b1;
                end
              end
            end
          end else if (key == KEY_BACK) begin
            err_lamp = 1'b0;
            err_run = 1'b0;
            err_tmr = '0;
            if (lk_count != 0) lk_count = lk_count - 3'd1;
          end
        end
        MODE_OPEN: begin
          if (key == KEY_REVISE) begin
            open_run = 1'b0;
            lk_count = '0;
            relay = 1'b0;
            revise_lamp = 1'b1;
            lk_mode = MODE_REVISE;
          end
        end
        default: begin
          if (key <= KEY_DIGIT_HI) begin
            // past the last position the last digit is written again
            if (lk_count < N_DIGITS) lk_count = lk_count + 3'd1;
            widx = lk_count - 3'd1;
            code_store[widx] = key;
            wr = 1'b1;
            wdig = key;
          end else if (key == KEY_BACK) begin
            if (lk_count != 0) lk_count = lk_count - 3'd1;
          end else if (key == KEY_REVISE) begin
            if (lk_count == N_DIGITS) begin
              lk_mode = MODE_CLOSED;
              revise_lamp = 1'b0;
            end
          end
        end
      endcase
    end
    v.mode = lk_mode;
    v.count = lk_count;
    v.relay = relay;
    v.err = err_lamp;
    v.entry = entry_lamp;
    v.revise = revise_lamp;
    v.wr = wr;
    v.idx = widx;
    v.dig = wdig;
    view_q.push_back(v);
  endtask

  // driver: one beat per accepted handshake, random gaps unless steady
  always @(posedge clk) begin : drive
    key_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_lock(in_func, in_key_code);
        n_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (beat_q.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
          nxt = beat_q.pop_front();
          in_valid <= 1'b1;
          in_func <= nxt.func;
          in_key_code <= nxt.key;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin : watch
    lock_view_t w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (view_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual mode %0d count %0d",
                   $time, out_lock_mode, out_digit_count);
          n_errors++;
        end else begin
          w = view_q.pop_front();
          check_field("lock_mode", w.mode, out_lock_mode);
          check_field("digit_count", w.count, out_digit_count);
          check_field("relay_on", w.relay, out_relay_on);
          check_field("error_lamp", w.err, out_error_lamp);
          check_field("entry_lamp", w.entry, out_entry_lamp);
          check_field("revise_lamp", w.revise, out_revise_lamp);
          check_field("store_write", w.wr, out_store_write);
          check_field("store_index", w.idx, out_store_index);
          check_field("store_digit", w.dig, out_store_digit);
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_OFF;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 19);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("[keypad_code_lock_controller] ERROR");
        $finish;
      end
    end
  end

  task automatic push_item(input logic fn, input logic [3:0] key);
    key_beat_t b;
    b.func = fn;
    b.key = key;
    beat_q.push_back(b);
    n_pushed++;
  endtask

  task automatic push_key(input logic [3:0] key);
    push_item(FUNC_KEY, key);
  endtask

  task automatic push_tick();
    push_item(FUNC_TICK, 4'($urandom_range(15)));
  endtask

  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) push_item(1'($urandom_range(1)), 4'($urandom_range(15)));
  endtask

  task automatic push_ticks_toward(input logic [7:0] hold, input logic [7:0] tmr);
    int rem;
    rem = int'(hold) - int'(tmr);
    if (rem < 1) rem = 1;
    if ($urandom_range(99) < 70 && rem > 40) rem = $urandom_range(1, 40);
    for (int i = 0; i < rem; i++) push_tick();
  endtask

  // wait until the block has nothing left to report
  task automatic settle();
    wait (n_taken == n_pushed);
    wait (view_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_OPEN_HOLD) open_hold = val;
    else err_hold = val;
  endtask

  task automatic set_holds(input logic [7:0] open_v, input logic [7:0] err_v);
    settle();
    write_reg(CFG_OPEN_HOLD, open_v);
    write_reg(CFG_ERROR_HOLD, err_v);
  endtask

  // open with the stored code, then revise it, over and over; no ticks
  task automatic push_chain(input int rounds);
    logic [3:0] shadow [N_DIGITS];
    for (int i = 0; i < N_DIGITS; i++) shadow[i] = code_store[i];
    for (int r = 0; r < rounds; r++) begin
      push_key(KEY_START);
      for (int i = 0; i < N_DIGITS; i++) push_key(shadow[i]);
      push_key(KEY_REVISE);
      for (int i = 0; i < N_DIGITS; i++) begin
        shadow[i] = 4'($urandom_range(9));
        push_key(shadow[i]);
      end
      push_key(KEY_REVISE);
    end
  endtask

  // next few beats chosen from the current lock state
  task automatic plan_next();
    int r;
    int n;
    bit bad;
    r = $urandom_range(99);
    case (lk_mode)
      MODE_CLOSED: begin
        if (r < 75) push_key(KEY_START);
        else push_noise($urandom_range(1, 4));
      end
      MODE_ENTRY: begin
        if (err_lamp) begin
          if (r < 40) push_key(KEY_BACK);
          else if (r < 85) push_ticks_toward(err_hold, err_tmr);
          else push_noise($urandom_range(1, 3));
        end else begin
          bad = 1'b0;
          for (int i = 0; i < lk_count; i++)
            if (code_typed[i] != code_store[i]) bad = 1'b1;
          if (bad && r < 60) begin
            push_key(KEY_BACK);
          end else if (r >= 93) begin
            push_noise($urandom_range(1, 3));
          end else begin
            for (int p = lk_count; p < N_DIGITS; p++) begin
              if ($urandom_range(99) < 88) push_key(code_store[p]);
              else push_key(4'($urandom_range(9)));
              if ($urandom_range(99) < 8) push_tick();
            end
          end
        end
      end
      MODE_OPEN: begin
        if (r < 45) push_key(KEY_REVISE);
        else if (r < 85) push_ticks_toward(open_hold, open_tmr);
        else push_noise($urandom_range(1, 3));
      end
      default: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(99) < 15) push_key(KEY_BACK);
          else push_key(4'($urandom_range(9)));
        end
        if ($urandom_range(99) < 80) push_key(KEY_REVISE);
      end
    endcase
  endtask

  task automatic run_random(input int n);
    int unsigned first;
    first = n_taken;
    while (n_taken - first < n) begin
      wait (n_taken == n_pushed);
      plan_next();
    end
  endtask

  initial begin
    reset_lock();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset holds: ignored keys, backspace at zero, reset code, full revise
    push_tick();
    push_key(KEY_SPARE);
    push_key(4'd15);
    push_key(KEY_START);
    push_key(KEY_BACK);
    repeat (5) push_key(STORED_RESET);
    push_key(KEY_BACK);
    push_key(STORED_RESET);
    push_key(STORED_RESET);
    push_key(KEY_REVISE);
    push_key(4'd9);
    for (int d = 0; d < 6; d++) push_key(4'(d));
    push_key(KEY_REVISE);

    // shortest holds: wrong code, full entry, backspace clears error, both expiries
    set_holds(8'd1, 8'd1);
    push_key(KEY_START);
    for (int i = 0; i < N_DIGITS; i++) push_key(4'((int'(code_store[i]) + 1) % 10));
    push_key(4'd7);
    push_key(KEY_BACK);
    push_key(4'((int'(code_store[N_DIGITS-1]) + 1) % 10));
    push_tick();
    push_key(KEY_START);
    for (int i = 0; i < N_DIGITS; i++) push_key(code_store[i]);
    push_tick();
    settle();

    // back to back beats on both sides
    steady = 1'b1;
    push_chain(6);
    settle();
    steady = 1'b0;

    // receiver holds off while the sender keeps offering
    push_chain(6);
    hold_req = 1'b1;
    settle();

    set_holds(8'd255, 8'd255);
    run_random(110);
    set_holds(8'd1, 8'd1);
    run_random(110);
    set_holds(8'd1, 8'd255);
    run_random(90);
    set_holds(8'd255, 8'd1);
    run_random(90);
    repeat (2) begin
      set_holds(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
      run_random(60);
    end

    settle();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("[keypad_code_lock_controller] OK");
    end else begin
      $display("[keypad_code_lock_controller] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/kclc_pkg.sv
src/kclc_cfg.sv
src/kclc_step.sv
src/keypad_code_lock_controller.sv
test/tb_keypad_code_lock_controller.sv
